>>> sv/interval_range_table_core_defines.svh
// Assertion macros used by the checker file.
`ifndef INTERVAL_RANGE_TABLE_CORE_DEFINES_SVH
`define INTERVAL_RANGE_TABLE_CORE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define IRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define IRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/irt_pkg.sv
package irt_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int TAG_BITS_DEF      = 16;
    localparam int ADDR_W            = 64;
    localparam int TAG_W             = 16;
    localparam int KIND_W            = 3;
    localparam int STATUS_W          = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OVERLAP = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EXACT   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] range_start;
        logic [ADDR_W-1:0] range_end;
        logic [TAG_W-1:0]  entry_tag;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [ADDR_W-1:0]   hit_start;
        logic [ADDR_W-1:0]   hit_end;
        logic [TAG_W-1:0]    hit_tag;
    } rsp_t;

    // Flags a cell reports for the current request.
    typedef struct packed {
        logic valid;
        logic contains;
        logic exact;
        logic le_end;
        logic cross_both;
    } cell_flags_t;

    // Update command broadcast to every cell.
    typedef struct packed {
        logic              trim;
        logic              split_take;
        logic              clear;
        logic [ADDR_W-1:0] cut_start;
        logic [ADDR_W-1:0] cut_end;
    } cell_cmd_t;

endpackage

>>> sv/irt_if.sv
interface irt_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> sv/interval_range_table_core.sv
// Lookups, overlap checks, clear, unused kinds and empty ranges go from SCAN
// straight to RESP; remove and an insert whose split finds the table full pass
// through UPDATE; insert goes through UPDATE and ADD. The result is registered
// once RESP finds the output free. One request at a time: no new request is
// taken until the last result is registered, and a held result stalls RESP.
// Reset: rst_n asynchronously empties the table and returns to idle.
module interval_range_table_core #(
    parameter int TABLE_ENTRIES = irt_pkg::TABLE_ENTRIES_DEF,
    parameter int TAG_BITS      = irt_pkg::TAG_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    irt_if.sink   req,
    irt_if.source rsp
);
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int TREE_N = 1 << IDX_W;

    irt_pkg::req_t              req_q;
    irt_pkg::cell_cmd_t         cmd;
    irt_pkg::cell_flags_t       flags [TABLE_ENTRIES];
    logic [irt_pkg::ADDR_W-1:0] starts [TABLE_ENTRIES];
    logic [irt_pkg::ADDR_W-1:0] ends [TABLE_ENTRIES];
    logic [TAG_BITS-1:0]        tags [TABLE_ENTRIES];
    logic [TABLE_ENTRIES:0]     free_ch;
    logic [irt_pkg::ADDR_W-1:0] cend [TABLE_ENTRIES+1];
    logic [TAG_BITS-1:0]        ctag [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0]   cross_v, split_sel;
    logic                       any_cross, table_full, ins_take, do_resp, out_free;
    logic                       split_full;
    logic                       out_valid_reg;
    logic                       full_reg;
    irt_pkg::rsp_t              rsp_reg, rsp_next;
    logic                       hit;
    logic [IDX_W-1:0]           hit_idx;
    logic [IDX_W-1:0]           best_idx;
    logic                       best_ok;
    logic                       t_ok  [2*TREE_N];
    logic [IDX_W-1:0]           t_idx [2*TREE_N];
    logic [irt_pkg::ADDR_W-1:0] t_key [2*TREE_N];
    logic [IDX_W-1:0]           donor_idx;

    // Feed the donor's end and tag in at the head of the chain so that a
    // free slot on either side of the donor sees them.
    assign free_ch[0] = 1'b0;
    assign cend[0]    = ends[donor_idx];
    assign ctag[0]    = tags[donor_idx];

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            assign cross_v[g] = flags[g].cross_both;
            irt_cell #(.TAG_BITS(TAG_BITS)) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .req           (req_q),
                .cmd           (cmd),
                .ins_take      (ins_take),
                .split_sel     (split_sel[g]),
                .free_in       (free_ch[g]),
                .free_out      (free_ch[g+1]),
                .chain_end_in  (cend[g]),
                .chain_tag_in  (ctag[g]),
                .chain_end_out (cend[g+1]),
                .chain_tag_out (ctag[g+1]),
                .flags         (flags[g]),
                .start_q       (starts[g]),
                .end_q         (ends[g]),
                .tag_q         (tags[g])
            );
        end
    endgenerate

    // Only one entry can straddle both edges of the range.
    always_comb
    begin
        donor_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (cross_v[i])
            begin
                donor_idx = IDX_W'(i);
            end
        end
    end
    assign split_sel  = cross_v;
    assign any_cross  = |cross_v;
    assign table_full = !free_ch[TABLE_ENTRIES];

    irt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .req_in     (req.payload),
        .req_q      (req_q),
        .any_cross  (any_cross),
        .table_full (table_full),
        .cmd        (cmd),
        .ins_take   (ins_take),
        .split_full (split_full),
        .do_resp    (do_resp),
        .out_free   (out_free)
    );

    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if ((req_q.kind == irt_pkg::KIND_LOOKUP && flags[i].contains)
                || (req_q.kind == irt_pkg::KIND_EXACT && flags[i].exact))
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
        // Pick the greatest start at or below the range end with a balanced tree.
        for (int k = 0; k < 2 * TREE_N; k++)
        begin
            t_ok[k]  = 1'b0;
            t_idx[k] = '0;
            t_key[k] = '0;
        end
        for (int i = 0; i < TREE_N; i++)
        begin
            if (i < TABLE_ENTRIES)
            begin
                t_ok[TREE_N + i]  = flags[i].le_end;
                t_key[TREE_N + i] = starts[i];
            end
            t_idx[TREE_N + i] = IDX_W'(i);
        end
        for (int k = TREE_N - 1; k >= 1; k--)
        begin
            if (t_ok[2*k+1] && (!t_ok[2*k] || t_key[2*k+1] > t_key[2*k]))
            begin
                t_ok[k]  = t_ok[2*k+1];
                t_idx[k] = t_idx[2*k+1];
                t_key[k] = t_key[2*k+1];
            end
            else
            begin
                t_ok[k]  = t_ok[2*k];
                t_idx[k] = t_idx[2*k];
                t_key[k] = t_key[2*k];
            end
        end
        best_ok  = t_ok[1];
        best_idx = t_idx[1];
    end

    always_comb
    begin
        rsp_next = '0;
        case (req_q.kind)
            irt_pkg::KIND_INSERT:
            begin
                if (req_q.range_start >= req_q.range_end)
                begin
                    rsp_next.status = irt_pkg::ST_INVALID;
                end
                else if (full_reg)
                begin
                    rsp_next.status = irt_pkg::ST_FULL;
                end
            end
            irt_pkg::KIND_REMOVE:
            begin
                rsp_next.status = full_reg ? irt_pkg::ST_FULL : irt_pkg::ST_OK;
            end
            irt_pkg::KIND_LOOKUP, irt_pkg::KIND_EXACT:
            begin
                if (hit)
                begin
                    rsp_next.found     = 1'b1;
                    rsp_next.hit_start = starts[hit_idx];
                    rsp_next.hit_end   = ends[hit_idx];
                    rsp_next.hit_tag   = irt_pkg::TAG_W'(tags[hit_idx]);
                end
            end
            irt_pkg::KIND_OVERLAP:
            begin
                if (best_ok && ends[best_idx] > req_q.range_start)
                begin
                    rsp_next.found     = 1'b1;
                    rsp_next.hit_start = starts[best_idx];
                    rsp_next.hit_end   = ends[best_idx];
                    rsp_next.hit_tag   = irt_pkg::TAG_W'(tags[best_idx]);
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    assign out_free = !out_valid_reg || rsp.ready;

    // Track full status while the request is in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            full_reg <= 1'b0;
        end
        else if (split_full || (ins_take && table_full))
        begin
            full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_resp)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_resp)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = rsp_reg;
endmodule

>>> sv/irt_cell.sv
// One table slot. Each cycle it forwards the split donor's end and tag to its
// right neighbor and takes them during a split if it is the first free slot.
module irt_cell #(
    parameter int TAG_BITS = irt_pkg::TAG_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  irt_pkg::req_t              req,
    input  irt_pkg::cell_cmd_t         cmd,
    input  logic                       ins_take,
    input  logic                       split_sel,
    input  logic                       free_in,
    output logic                       free_out,
    input  logic [irt_pkg::ADDR_W-1:0] chain_end_in,
    input  logic [TAG_BITS-1:0]        chain_tag_in,
    output logic [irt_pkg::ADDR_W-1:0] chain_end_out,
    output logic [TAG_BITS-1:0]        chain_tag_out,
    output irt_pkg::cell_flags_t       flags,
    output logic [irt_pkg::ADDR_W-1:0] start_q,
    output logic [irt_pkg::ADDR_W-1:0] end_q,
    output logic [TAG_BITS-1:0]        tag_q
);
    logic                       valid_reg, valid_next;
    logic [irt_pkg::ADDR_W-1:0] start_reg, start_next;
    logic [irt_pkg::ADDR_W-1:0] end_reg, end_next;
    logic [TAG_BITS-1:0]        tag_reg, tag_next;
    logic                       first_free;
    logic                       ovl;

    assign first_free = !valid_reg && !free_in;
    assign free_out   = free_in || !valid_reg;

    // Pass the donor's fields rightward; the donor injects its own.
    assign chain_end_out = split_sel ? end_reg : chain_end_in;
    assign chain_tag_out = split_sel ? tag_reg : chain_tag_in;

    assign flags.valid      = valid_reg;
    assign flags.contains   = valid_reg && start_reg <= req.range_start
                              && req.range_start < end_reg;
    assign flags.exact      = valid_reg && start_reg == req.range_start;
    assign flags.le_end     = valid_reg && start_reg <= req.range_end;
    assign flags.cross_both = valid_reg && start_reg < req.range_start
                              && end_reg > req.range_end;

    assign ovl = start_reg < cmd.cut_end && end_reg > cmd.cut_start;

    always_comb
    begin
        valid_next = valid_reg;
        start_next = start_reg;
        end_next   = end_reg;
        tag_next   = tag_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.split_take)
        begin
            if (split_sel)
            begin
                end_next = cmd.cut_start;
            end
            else if (first_free)
            begin
                valid_next = 1'b1;
                start_next = cmd.cut_end;
                end_next   = chain_end_in;
                tag_next   = chain_tag_in;
            end
        end
        else if (cmd.trim && valid_reg && ovl)
        begin
            if (start_reg >= cmd.cut_start && end_reg <= cmd.cut_end)
            begin
                valid_next = 1'b0;
            end
            else if (start_reg < cmd.cut_start)
            begin
                end_next = cmd.cut_start;
            end
            else
            begin
                start_next = cmd.cut_end;
            end
        end
        else if (ins_take && first_free)
        begin
            valid_next = 1'b1;
            start_next = req.range_start;
            end_next   = req.range_end;
            tag_next   = TAG_BITS'(req.entry_tag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
        tag_reg   <= tag_next;
    end

    assign start_q = start_reg;
    assign end_q   = end_reg;
    assign tag_q   = tag_reg;
endmodule

>>> sv/irt_ctrl.sv
// Sequencer: SCAN picks the path by kind, UPDATE applies the trim or split (remove, insert),
// ADD places the new entry (insert), then RESP registers the response and applies a clear.
module irt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  irt_pkg::req_t        req_in,
    output irt_pkg::req_t        req_q,
    input  logic                 any_cross,
    input  logic                 table_full,
    output irt_pkg::cell_cmd_t   cmd,
    output logic                 ins_take,
    output logic                 split_full,
    output logic                 do_resp,
    input  logic                 out_free
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0]         state_reg, state_next;
    irt_pkg::req_t      req_reg;
    logic               is_ins, is_rem, empty_rng;

    assign req_q     = req_reg;
    assign in_ready  = state_reg == S_IDLE;
    assign is_ins    = req_reg.kind == irt_pkg::KIND_INSERT;
    assign is_rem    = req_reg.kind == irt_pkg::KIND_REMOVE;
    assign empty_rng = req_reg.range_start >= req_reg.range_end;

    always_comb
    begin
        cmd            = '0;
        cmd.cut_start  = req_reg.range_start;
        cmd.cut_end    = req_reg.range_end;
        ins_take       = 1'b0;
        split_full     = 1'b0;
        do_resp        = 1'b0;
        state_next     = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if ((is_ins || is_rem) && !empty_rng)
                begin
                    state_next = S_UPD;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_UPD:
            begin
                if (any_cross)
                begin
                    cmd.split_take = !table_full;
                end
                else
                begin
                    cmd.trim = 1'b1;
                end
                split_full = any_cross && table_full;
                state_next = (is_ins && !(any_cross && table_full)) ? S_ADD : S_RESP;
            end
            S_ADD:
            begin
                ins_take   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    do_resp    = 1'b1;
                    cmd.clear  = req_reg.kind == irt_pkg::KIND_CLEAR;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_reg <= req_in;
        end
    end
endmodule

>>> sv/irt_checker.sv
`include "interval_range_table_core_defines.svh"

module irt_props (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input irt_pkg::rsp_t rsp_payload
);
    `IRT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_payload), "result dropped while stalled")
    `IRT_ASSERT_NEXT(a_one_at_time, clk, rst_n, req_valid && req_ready,
        !req_ready, "request taken while another is in flight")
    `IRT_ASSERT_IMP(a_status_range, clk, rst_n, rsp_valid,
        rsp_payload.status != 2'd3, "bad status code")
    `IRT_ASSERT_IMP(a_found_ok, clk, rst_n, rsp_valid && rsp_payload.found,
        rsp_payload.status == irt_pkg::ST_OK, "hit with error status")
endmodule

bind interval_range_table_core irt_props u_irt_props (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
